/* hdl/dtl_pkg.sv */
`default_nettype none
package dtl_pkg;

    localparam int TBL_DEPTH = 16;
    localparam int IDX_W     = $clog2(TBL_DEPTH);
    localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
    localparam int NKNOWN    = 13;

    typedef enum logic [1:0] {
        KIND_OBSERVE = 2'd0,
        KIND_PRUNE   = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_STALE_LIMIT = 2'd0,
        CFG_NO_COMPANY  = 2'd1,
        CFG_NO_POWER    = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRUNE,
        ST_RESULT
    } t_state;

    localparam logic [15:0] KNOWN_IDS [NKNOWN] = '{
        16'h004C, 16'h0006, 16'h0075, 16'h00E0, 16'h0087, 16'h0002, 16'h000F,
        16'h0059, 16'h0157, 16'h038F, 16'h00D7, 16'h009E, 16'h02E5
    };

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        now_ms;
        logic [47:0]        dev_addr;
        logic signed [7:0]  sig_strength;
        logic [15:0]        company;
        logic signed [7:0]  adv_power;
        logic [15:0]        device_class;
        logic               has_name;
        logic [3:0]         read_index;
    } t_obs;

    typedef struct packed {
        logic [4:0]         entry_count;
        logic signed [7:0]  strongest;
        logic [4:0]         named_count;
        logic [4:0]         known_count;
        logic [47:0]        out_addr;
        logic signed [7:0]  out_strength;
        logic [15:0]        out_company;
        logic signed [7:0]  out_power;
        logic [15:0]        out_class;
        logic [31:0]        out_last_seen;
        logic               out_named;
        logic               out_valid;
    } t_res;

    typedef struct packed {
        logic [47:0]        addr;
        logic signed [7:0]  strength;
        logic [31:0]        seen;
        logic [15:0]        company;
        logic signed [7:0]  power;
        logic [15:0]        cls;
        logic               named;
    } t_entry;

    // Search packet that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [47:0]        addr;
        logic               found;
        logic [IDX_W-1:0]   match_idx;
        logic [31:0]        oldest;
        logic [IDX_W-1:0]   old_idx;
        logic signed [7:0]  best;
        logic [CNT_W-1:0]   named;
        logic [CNT_W-1:0]   known;
    } t_scan;

    function automatic logic is_known(input logic [15:0] c, input logic [15:0] none_code);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NKNOWN; k++) begin
            if (KNOWN_IDS[k] == c) hit = 1'b1;
        end
        return hit && (c != none_code);
    endfunction

endpackage
`default_nettype wire

/* hdl/dtl_if.sv */
`default_nettype none
interface dtl_obs_if;
    import dtl_pkg::*;
    logic valid;
    logic ready;
    t_obs payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dtl_res_if;
    import dtl_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dtl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

/* hdl/device_table_lru_aging_unit.sv */
`default_nettype none
// Device learning table with least-recently-seen eviction and aging.
// Items arrive on i_obs (valid/ready); each beat carries a kind: observe,
// prune, summary or read. Every accepted item yields exactly one result beat
// on o_res. Registers (stale limit, no-company code, no-power code) are
// written on i_cfg, which is always ready; the user must write them only
// while the block is idle, which the block itself does not enforce. The
// table lives in a row of sixteen cells. Observe and summary send a search
// packet down the row, one cell per cycle, and the result beat is formed
// when the packet leaves the last cell. A read answers in the cycle after
// acceptance. A prune walks the table one position per cycle. One item
// is in work at a time; a new beat is taken only in the cycle after the
// previous result has left.
// Reset empties the table (entry count zero) and loads the register
// defaults; entry contents are not cleared. When the receiver stalls, the
// result beat holds on o_res and no new item is accepted.
module device_table_lru_aging_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtl_obs_if.sink   i_obs,
    dtl_res_if.source o_res,
    dtl_cfg_if.sink   i_cfg
);
    import dtl_pkg::*;

    t_entry w_ent  [TBL_DEPTH];
    t_scan  w_scan [TBL_DEPTH+1];

    t_state           r_state, n_state;
    t_obs             r_item, n_item;
    t_res             r_res, n_res;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [31:0]      r_stale;
    logic [15:0]      r_no_comp;
    logic signed [7:0] r_no_pow;

    logic             inject;
    logic             we;
    logic [IDX_W-1:0] widx;
    t_entry           wdata;
    t_scan            head;

    // Configuration port: always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale   <= 32'd20000;
            r_no_comp <= 16'hFFFF;
            r_no_pow  <= 8'sd127;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.reg_index))
                CFG_STALE_LIMIT: r_stale   <= i_cfg.wdata;
                CFG_NO_COMPANY:  r_no_comp <= i_cfg.wdata[15:0];
                CFG_NO_POWER:    r_no_pow  <= i_cfg.wdata[7:0];
                default: ;
            endcase
        end
    end

    // Search packet entering the first cell.
    always_comb begin
        head.valid     = inject;
        head.addr      = r_item.dev_addr;
        head.found     = 1'b0;
        head.match_idx = '0;
        head.oldest    = r_item.now_ms;
        head.old_idx   = '0;
        head.best      = 8'sd0;
        head.named     = '0;
        head.known     = '0;
    end
    assign w_scan[0] = head;

    for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_cell
        dtl_cell #(.CELL_IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_scan      (w_scan[g]),
            .i_used      (r_used),
            .i_no_company(r_no_comp),
            .i_we        (we),
            .i_widx      (widx),
            .i_wdata     (wdata),
            .o_scan      (w_scan[g+1]),
            .o_entry     (w_ent[g])
        );
    end

    assign i_obs.ready   = (r_state == ST_IDLE);
    assign o_res.valid   = (r_state == ST_RESULT);
    assign o_res.payload = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
        r_item <= n_item;
        r_res  <= n_res;
        r_pos  <= n_pos;
    end

    always_comb begin
        t_scan            tail;
        t_entry           base;
        t_entry           rd;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] last;
        logic [31:0]      age;

        n_state = r_state;
        n_item  = r_item;
        n_res   = r_res;
        n_used  = r_used;
        n_pos   = r_pos;
        inject  = 1'b0;
        we      = 1'b0;
        widx    = '0;
        wdata   = w_ent[0];
        tail    = w_scan[TBL_DEPTH];
        base    = w_ent[0];
        slot    = '0;
        last    = r_used[IDX_W-1:0] - IDX_W'(1);
        age     = '0;
        rd      = w_ent[i_obs.payload.read_index];

        case (r_state)
            ST_IDLE: begin
                if (i_obs.valid) begin
                    n_item = i_obs.payload;
                    n_res  = '0;
                    n_pos  = '0;
                    case (t_kind'(i_obs.payload.kind))
                        KIND_OBSERVE, KIND_SUMMARY: n_state = ST_SCAN;
                        KIND_PRUNE:                 n_state = ST_PRUNE;
                        default: begin
                            // Read: answer straight from the addressed cell.
                            n_res.entry_count = r_used;
                            if (CNT_W'(i_obs.payload.read_index) < r_used) begin
                                n_res.out_addr      = rd.addr;
                                n_res.out_strength  = rd.strength;
                                n_res.out_company   = rd.company;
                                n_res.out_power     = rd.power;
                                n_res.out_class     = rd.cls;
                                n_res.out_last_seen = rd.seen;
                                n_res.out_named     = rd.named;
                                n_res.out_valid     = 1'b1;
                            end
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The packet is launched on the first scan cycle and picked
                // up when it leaves the last cell.
                inject = !r_pos[0];
                n_pos  = {{(CNT_W-1){1'b0}}, 1'b1};
                if (tail.valid) begin
                    if (t_kind'(r_item.kind) == KIND_SUMMARY) begin
                        n_res.strongest   = tail.best;
                        n_res.named_count = tail.named;
                        n_res.known_count = tail.known;
                    end else begin
                        if (tail.found) begin
                            slot = tail.match_idx;
                            base = w_ent[tail.match_idx];
                        end else begin
                            if (r_used < CNT_W'(TBL_DEPTH)) begin
                                slot   = r_used[IDX_W-1:0];
                                n_used = r_used + CNT_W'(1);
                            end else begin
                                slot = tail.old_idx;
                            end
                            base.addr    = r_item.dev_addr;
                            base.company = r_no_comp;
                            base.power   = r_no_pow;
                            base.cls     = '0;
                            base.named   = 1'b0;
                        end
                        wdata          = base;
                        wdata.strength = r_item.sig_strength;
                        wdata.seen     = r_item.now_ms;
                        if (r_item.company != r_no_comp) wdata.company = r_item.company;
                        if (r_item.adv_power != r_no_pow) wdata.power = r_item.adv_power;
                        if (r_item.device_class != 16'd0) wdata.cls = r_item.device_class;
                        if (r_item.has_name) wdata.named = 1'b1;
                        we   = 1'b1;
                        widx = slot;
                    end
                    n_res.entry_count = n_used;
                    n_state           = ST_RESULT;
                end
            end
            ST_PRUNE: begin
                // One position per cycle: a stale entry takes the last
                // entry's place and is tested again at the same position.
                if (r_pos < r_used) begin
                    age = r_item.now_ms - w_ent[r_pos[IDX_W-1:0]].seen;
                    if (age > r_stale) begin
                        we     = 1'b1;
                        widx   = r_pos[IDX_W-1:0];
                        wdata  = w_ent[last];
                        n_used = r_used - CNT_W'(1);
                    end else begin
                        n_pos = r_pos + CNT_W'(1);
                    end
                end else begin
                    n_res.entry_count = r_used;
                    n_state           = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/dtl_cell.sv */
`default_nettype none
module dtl_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dtl_pkg::t_scan  i_scan,
    input  wire logic [dtl_pkg::CNT_W-1:0] i_used,
    input  wire logic [15:0]     i_no_company,
    input  wire logic            i_we,
    input  wire logic [dtl_pkg::IDX_W-1:0] i_widx,
    input  wire dtl_pkg::t_entry i_wdata,
    output dtl_pkg::t_scan       o_scan,
    output dtl_pkg::t_entry      o_entry
);
    import dtl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    t_entry r_entry;
    t_scan  r_scan, n_scan;
    logic   active;

    assign active = CNT_W'(CELL_IDX) < i_used;

    always_comb begin
        n_scan = i_scan;
        if (active) begin
            if (!i_scan.found && r_entry.addr == i_scan.addr) begin
                n_scan.found     = 1'b1;
                n_scan.match_idx = MY_IDX;
            end
            if (r_entry.seen <= i_scan.oldest) begin
                n_scan.oldest  = r_entry.seen;
                n_scan.old_idx = MY_IDX;
            end
            if (CELL_IDX == 0 || r_entry.strength > i_scan.best) begin
                n_scan.best = r_entry.strength;
            end
            n_scan.named = i_scan.named + CNT_W'(r_entry.named);
            n_scan.known = i_scan.known + CNT_W'(is_known(r_entry.company, i_no_company));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= i_scan.valid;
        end
        r_scan.addr      <= n_scan.addr;
        r_scan.found     <= n_scan.found;
        r_scan.match_idx <= n_scan.match_idx;
        r_scan.oldest    <= n_scan.oldest;
        r_scan.old_idx   <= n_scan.old_idx;
        r_scan.best      <= n_scan.best;
        r_scan.named     <= n_scan.named;
        r_scan.known     <= n_scan.known;
        if (i_we && i_widx == MY_IDX) begin
            r_entry <= i_wdata;
        end
    end

    assign o_scan  = r_scan;
    assign o_entry = r_entry;

endmodule
`default_nettype wire

/* tb/device_table_lru_aging_unit_tb.sv */
`default_nettype none
module device_table_lru_aging_unit_tb;
    import dtl_pkg::*;

    // Clock, reset and the three channels of the block.
    logic i_clk;
    logic i_rst_n;

    dtl_obs_if obs ();
    dtl_res_if res ();
    dtl_cfg_if cfg ();

    device_table_lru_aging_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_obs  (obs),
        .o_res  (res),
        .i_cfg  (cfg)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Company identifiers that the summary counts as known vendors.
    localparam logic [15:0] VENDOR_IDS [13] = '{
        16'h004C, 16'h0006, 16'h0075, 16'h00E0, 16'h0087, 16'h0002, 16'h000F,
        16'h0059, 16'h0157, 16'h038F, 16'h00D7, 16'h009E, 16'h02E5
    };
    localparam int ITEMS_PER_PHASE = 150;
    localparam int CYCLE_LIMIT     = 400000;

    // Local copy of the device table and of the three registers.
    t_entry      dev_table [TBL_DEPTH];
    int          dev_count;
    logic [31:0] stale_limit;
    logic [15:0] absent_company;
    logic [7:0]  absent_power;

    t_res pending_results [$];
    int   failures;
    int   cycle_count;
    logic tx_burst;
    logic rx_burst;

    function automatic logic vendor_known(input logic [15:0] c);
        logic hit;
        hit = 1'b0;
        foreach (VENDOR_IDS[k]) begin
            if (VENDOR_IDS[k] == c) hit = 1'b1;
        end
        return hit && (c != absent_company);
    endfunction

    // Applies one item to the local table and returns the result beat the
    // block must produce for it.
    function automatic t_res table_predict(input t_obs it);
        t_res        r;
        int          slot;
        int          i;
        logic        hit;
        logic [31:0] oldest;
        logic [31:0] age;
        r = '0;
        case (it.kind)
            KIND_OBSERVE: begin
                hit  = 1'b0;
                slot = 0;
                for (i = 0; i < dev_count; i++) begin
                    if (!hit && dev_table[i].addr == it.dev_addr) begin
                        hit  = 1'b1;
                        slot = i;
                    end
                end
                if (!hit) begin
                    if (dev_count < TBL_DEPTH) begin
                        slot = dev_count;
                        dev_count++;
                    end else begin
                        // Oldest entry at or before now wins; ties go to the
                        // highest position, and with none at all position 0.
                        oldest = it.now_ms;
                        slot   = 0;
                        for (i = 0; i < TBL_DEPTH; i++) begin
                            if (dev_table[i].seen <= oldest) begin
                                oldest = dev_table[i].seen;
                                slot   = i;
                            end
                        end
                    end
                    dev_table[slot].addr    = it.dev_addr;
                    dev_table[slot].company = absent_company;
                    dev_table[slot].power   = absent_power;
                    dev_table[slot].cls     = '0;
                    dev_table[slot].named   = 1'b0;
                end
                dev_table[slot].strength = it.sig_strength;
                dev_table[slot].seen     = it.now_ms;
                if (it.company != absent_company) dev_table[slot].company = it.company;
                if (it.adv_power != absent_power) dev_table[slot].power = it.adv_power;
                if (it.device_class != 0) dev_table[slot].cls = it.device_class;
                if (it.has_name) dev_table[slot].named = 1'b1;
            end
            KIND_PRUNE: begin
                // A stale entry is replaced by the last one, which is then
                // tested at the same position.
                i = 0;
                while (i < dev_count) begin
                    age = it.now_ms - dev_table[i].seen;
                    if (age > stale_limit) begin
                        dev_count--;
                        dev_table[i] = dev_table[dev_count];
                    end else begin
                        i++;
                    end
                end
            end
            KIND_SUMMARY: begin
                for (i = 0; i < dev_count; i++) begin
                    if (i == 0 || dev_table[i].strength > r.strongest) begin
                        r.strongest = dev_table[i].strength;
                    end
                    if (dev_table[i].named) r.named_count++;
                    if (vendor_known(dev_table[i].company)) r.known_count++;
                end
            end
            default: begin
                if (it.read_index < dev_count) begin
                    r.out_addr      = dev_table[it.read_index].addr;
                    r.out_strength  = dev_table[it.read_index].strength;
                    r.out_company   = dev_table[it.read_index].company;
                    r.out_power     = dev_table[it.read_index].power;
                    r.out_class     = dev_table[it.read_index].cls;
                    r.out_last_seen = dev_table[it.read_index].seen;
                    r.out_named     = dev_table[it.read_index].named;
                    r.out_valid     = 1'b1;
                end
            end
        endcase
        r.entry_count = dev_count[4:0];
        return r;
    endfunction

    function automatic t_obs mk_item(input t_kind k, input logic [31:0] now,
                                     input logic [47:0] addr, input logic [7:0] rssi,
                                     input logic [15:0] comp, input logic [7:0] pwr,
                                     input logic [15:0] cls, input logic nm,
                                     input logic [3:0] idx);
        t_obs it;
        it.kind         = k;
        it.now_ms       = now;
        it.dev_addr     = addr;
        it.sig_strength = rssi;
        it.company      = comp;
        it.adv_power    = pwr;
        it.device_class = cls;
        it.has_name     = nm;
        it.read_index   = idx;
        return it;
    endfunction

    // Mostly short gaps, now and then a long one, none at all in a burst.
    function automatic int pick_gap(input logic burst);
        int p;
        p = $urandom_range(0, 99);
        if (burst || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp,
                               input logic [63:0] act);
        if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            failures++;
        end
    endtask

    // Sends one item, waits for its beat to be taken and records what the
    // block must answer. A typed expectation overrides the prediction.
    task automatic send_item(input t_obs it, input logic typed, input t_res fixed);
        int   gap;
        t_res predicted;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            obs.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        obs.valid   <= 1'b1;
        obs.payload <= it;
        do @(posedge i_clk); while (!obs.ready);
        predicted = table_predict(it);
        pending_results.push_back(typed ? fixed : predicted);
    endtask

    // Waits until every result is back plus the longest item latency.
    task automatic drain();
        obs.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] value);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wdata     <= value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            CFG_STALE_LIMIT: stale_limit    = value;
            CFG_NO_COMPANY:  absent_company = value[15:0];
            default:         absent_power   = value[7:0];
        endcase
    endtask

    // Result checker: every accepted beat is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_res exp;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no item outstanding");
                failures++;
            end else begin
                exp = pending_results.pop_front();
                check_field("entry_count",   exp.entry_count,   res.payload.entry_count);
                check_field("strongest",     exp.strongest,     res.payload.strongest);
                check_field("named_count",   exp.named_count,   res.payload.named_count);
                check_field("known_count",   exp.known_count,   res.payload.known_count);
                check_field("out_addr",      exp.out_addr,      res.payload.out_addr);
                check_field("out_strength",  exp.out_strength,  res.payload.out_strength);
                check_field("out_company",   exp.out_company,   res.payload.out_company);
                check_field("out_power",     exp.out_power,     res.payload.out_power);
                check_field("out_class",     exp.out_class,     res.payload.out_class);
                check_field("out_last_seen", exp.out_last_seen, res.payload.out_last_seen);
                check_field("out_named",     exp.out_named,     res.payload.out_named);
                check_field("out_valid",     exp.out_valid,     res.payload.out_valid);
            end
        end
    end

    // Receiver back-pressure, with the same mix of short and long stalls.
    initial begin
        int stall;
        forever begin
            stall = pick_gap(rx_burst);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[device_table_lru_aging_unit] ERROR");
            $finish;
        end
    end

    typedef struct {
        t_obs item;
        logic typed;
        t_res fixed;
    } t_row;

    // Main sequence: directed rows, then phases of random traffic under
    // different register settings.
    initial begin
        t_row        rows [$];
        t_row        row;
        t_res        zero_res;
        t_res        r;
        logic [47:0] addr_pool [20];
        logic [31:0] clock_ms;
        logic [31:0] phase_limit [5];
        logic [15:0] phase_company [5];
        logic [7:0]  phase_power [5];
        t_obs        it;
        int          p;
        int          n;

        failures       = 0;
        cycle_count    = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        i_rst_n       <= 1'b0;
        obs.valid     <= 1'b0;
        obs.payload   <= '0;
        cfg.valid     <= 1'b0;
        cfg.reg_index <= CFG_STALE_LIMIT;
        cfg.wdata     <= '0;

        // Reset loads the register defaults and empties the table.
        stale_limit    = 32'd20000;
        absent_company = 16'hFFFF;
        absent_power   = 8'd127;
        dev_count      = 0;
        foreach (dev_table[i]) dev_table[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        zero_res = '0;
        row.typed = 1'b1;
        row.fixed = zero_res;
        // Empty table: summary, read and prune all answer with zeros.
        row.item = mk_item(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_PRUNE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.typed = 1'b0;
        // Field extremes on a first entry, then an entry with all values absent.
        row.item = mk_item(KIND_OBSERVE, 100, 48'hFFFF_FFFF_FFFF, 8'h80, 16'h004C,
                           8'h80, 16'hFFFF, 1'b1, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_OBSERVE, 200, 0, 8'h7F, 16'hFFFF, 8'h7F, 0, 0, 0);
        rows.push_back(row);
        // Refresh of the same address with present, then absent values.
        row.item = mk_item(KIND_OBSERVE, 300, 0, 8'd5, 16'h02E5, 8'd4, 16'd1, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_OBSERVE, 400, 0, 8'hFF, 16'hFFFF, 8'h7F, 0, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4'd1);
        rows.push_back(row);
        row.item = mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4'd0);
        rows.push_back(row);
        // A read past the entry count returns only the count.
        row.typed = 1'b1;
        row.fixed = zero_res;
        row.fixed.entry_count = 5'd2;
        row.item = mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4'd15);
        rows.push_back(row);
        row.typed = 1'b0;
        row.item = mk_item(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_OBSERVE, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 8'd0,
                           16'h1234, 8'h7F, 16'd8, 1'b1, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        // Ages across the wrap: two entries go stale, one sits at the limit.
        row.item = mk_item(KIND_PRUNE, 32'd20400, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4'd0);
        rows.push_back(row);
        row.item = mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 4'd1);
        rows.push_back(row);
        row.item = mk_item(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);
        row.item = mk_item(KIND_PRUNE, 32'd400, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(row);

        foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].fixed);
        drain();

        // Register settings per phase; the first keeps the reset defaults.
        phase_limit   = '{32'd20000, 32'd0, 32'hFFFF_FFFF, 32'd500, 32'd20000};
        phase_company = '{16'hFFFF, 16'h0000, 16'h004C, 16'h1234, 16'hFFFF};
        phase_power   = '{8'd127, 8'h80, 8'h00, 8'hFF, 8'd127};
        foreach (addr_pool[k]) addr_pool[k] = 48'({$urandom(), $urandom()});
        clock_ms = 32'd1000;

        for (p = 0; p < 5; p++) begin
            if (p > 0) begin
                // Upper data bits of the narrow registers are don't-care.
                write_reg(CFG_STALE_LIMIT, phase_limit[p]);
                write_reg(CFG_NO_COMPANY,
                          {16'($urandom_range(0, 65535)), phase_company[p]});
                write_reg(CFG_NO_POWER,
                          {24'($urandom_range(0, 16777215)), phase_power[p]});
                cfg.valid <= 1'b0;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
                else clock_ms = clock_ms + $urandom_range(0, 3000);
                it = '0;
                it.now_ms       = clock_ms;
                it.dev_addr     = ($urandom_range(0, 9) < 8) ?
                                  addr_pool[$urandom_range(0, 19)] :
                                  48'({$urandom(), $urandom()});
                it.sig_strength = 8'($urandom());
                case ($urandom_range(0, 2))
                    0: it.company = absent_company;
                    1: it.company = VENDOR_IDS[$urandom_range(0, 12)];
                    default: it.company = 16'($urandom());
                endcase
                it.adv_power    = ($urandom_range(0, 2) == 0) ? absent_power : 8'($urandom());
                it.device_class = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom());
                it.has_name     = 1'($urandom_range(0, 1));
                it.read_index   = 4'($urandom());
                case ($urandom_range(0, 99)) inside
                    [0:59]:  it.kind = KIND_OBSERVE;
                    [60:71]: it.kind = KIND_PRUNE;
                    [72:85]: it.kind = KIND_SUMMARY;
                    default: it.kind = KIND_READ;
                endcase
                // Occasionally age a prune far enough to empty the table under the smaller stale limits.
                if (it.kind == KIND_PRUNE && $urandom_range(0, 4) == 0) begin
                    it.now_ms = clock_ms + 32'd40000;
                end
                send_item(it, 1'b0, zero_res);
            end
            drain();
        end

        if (failures == 0) begin
            $display("[device_table_lru_aging_unit] OK");
        end else begin
            $display("[device_table_lru_aging_unit] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* device_table_lru_aging_unit.f */
hdl/dtl_pkg.sv
hdl/dtl_if.sv
hdl/dtl_cell.sv
hdl/device_table_lru_aging_unit.sv
tb/device_table_lru_aging_unit_tb.sv
